>>> sv/sfw_pkg.sv
package sfw_pkg;

    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [7:0]  EXP_MAX     = 8'hFF;

    // Operand for the normalize/round pipe.
    // Value is sig * 2^(k - 158): bit 31 of sig weighs 2^(k - 127).
    typedef struct packed {
        logic               sign;
        logic signed [10:0] k;
        logic [31:0]        sig;
        logic               force_en;   // bypass rounding, emit force_val
        logic [31:0]        force_val;
    } nr_in_t;

    function automatic logic is_nan(input logic [31:0] v);
        is_nan = (v[30:23] == EXP_MAX) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] v);
        is_inf = (v[30:23] == EXP_MAX) && (v[22:0] == 23'd0);
    endfunction

    // Leading zero count, five halving steps
    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [31:0] x;
        logic [5:0]  n;
        x = v;
        n = 6'd0;
        if (x == 32'd0) begin
            n = 6'd32;
        end else begin
            if (x[31:16] == 16'd0) begin n = n + 6'd16; x = x << 16; end
            if (x[31:24] == 8'd0)  begin n = n + 6'd8;  x = x << 8;  end
            if (x[31:28] == 4'd0)  begin n = n + 6'd4;  x = x << 4;  end
            if (x[31:30] == 2'd0)  begin n = n + 6'd2;  x = x << 2;  end
            if (x[31] == 1'b0)     begin n = n + 6'd1; end
        end
        lzc32 = n;
    endfunction

endpackage

>>> sv/sfw_norm_round.sv
module sfw_norm_round (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sfw_pkg::nr_in_t     in_op,
    input  logic [31:0]         in_aux,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         out_res,
    output logic [31:0]         out_aux
);

    // stage 1: leading zero count
    logic            s1_valid_reg;
    sfw_pkg::nr_in_t s1_op_reg;
    logic [5:0]      s1_lz_reg;
    logic [31:0]     s1_aux_reg;
    logic            s1_ready;

    // stage 2: rounded result
    logic            s2_valid_reg;
    logic [31:0]     s2_res_reg;
    logic [31:0]     s2_aux_reg;
    logic            s2_ready;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_op_reg  <= in_op;
            s1_lz_reg  <= sfw_pkg::lzc32(in_op.sig);
            s1_aux_reg <= in_aux;
        end
    end

    logic signed [10:0] eb;
    logic signed [10:0] sh;
    logic signed [10:0] base;
    logic signed [10:0] rsh;
    logic signed [10:0] field;
    logic [31:0]        n;
    logic [31:0]        lost_mask;
    logic               inc;
    logic [30:0]        mag;
    logic [31:0]        res_next;

    always_comb
    begin
        eb = s1_op_reg.k - $signed({5'd0, s1_lz_reg});
        if (eb > 11'sd0)
        begin
            sh   = $signed({5'd0, s1_lz_reg});
            base = eb;
        end
        else
        begin
            // subnormal: pin bit 31 to weight 2^-126
            sh   = s1_op_reg.k - 11'sd1;
            base = 11'sd1;
        end
        rsh       = -sh;
        lost_mask = (32'd1 << rsh[4:0]) - 32'd1;
        if (sh >= 11'sd0)
        begin
            n = s1_op_reg.sig << sh[5:0];
        end
        else if (rsh >= 11'sd32)
        begin
            n = {31'd0, |s1_op_reg.sig};
        end
        else
        begin
            n = (s1_op_reg.sig >> rsh[4:0])
                | {31'd0, |(s1_op_reg.sig & lost_mask)};
        end
        field = base - 11'sd1 + $signed({10'd0, n[31]});
        inc   = n[7] && (n[8] || (n[6:0] != 7'd0));
        mag   = {field[7:0], n[30:8]} + {30'd0, inc};
        if (s1_op_reg.force_en)
        begin
            res_next = s1_op_reg.force_val;
        end
        else if (eb >= 11'sd255)
        begin
            res_next = {s1_op_reg.sign, sfw_pkg::EXP_MAX, 23'd0};
        end
        else
        begin
            res_next = {s1_op_reg.sign, mag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_res_reg <= res_next;
            s2_aux_reg <= s1_aux_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_res   = s2_res_reg;
    assign out_aux   = s2_aux_reg;

endmodule

>>> sv/split_fp32_weight_update_unit.sv
// Stages, each a register with its own valid bit: multiply, 2 normalize/round,
//   align, add, 2 normalize/round. Stages advance independently, bubbles collapse.
// Throughput: one item per cycle while out_ready is high.
// Reset (rst_n, async active low) clears all valid bits and alpha to 0.
module split_fp32_weight_update_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] old_high,
    input  logic [15:0] old_low,
    input  logic [15:0] grad,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] new_high,
    output logic [15:0] new_low
);

    // learning-rate scale, fp32 pattern
    logic [31:0] alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            alpha_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: product alpha * g. g is bf16 so its significand is 8 bits
    // and the 24x8 product is exact in 32 bits.
    // ------------------------------------------------------------------
    logic [31:0]     g_w;
    logic [31:0]     w_in;
    logic [7:0]      ea;
    logic [7:0]      eg;
    logic            a_zero;
    logic            g_zero;
    logic            p_sign;
    logic [23:0]     sig_a;
    logic [7:0]      sig_g;
    sfw_pkg::nr_in_t a_op_next;

    assign g_w  = {grad, 16'd0};
    assign w_in = {old_high, old_low};

    always_comb
    begin
        ea     = alpha_reg[30:23];
        eg     = g_w[30:23];
        a_zero = (alpha_reg[30:0] == 31'd0);
        g_zero = (g_w[30:0] == 31'd0);
        p_sign = alpha_reg[31] ^ g_w[31];
        sig_a  = {ea != 8'd0, alpha_reg[22:0]};
        sig_g  = {eg != 8'd0, g_w[22:16]};

        a_op_next.sign      = p_sign;
        // K = ea' + eg' - 126, with subnormal exponents read as 1
        a_op_next.k         = $signed({3'd0, (ea == 8'd0) ? 8'd1 : ea})
                            + $signed({3'd0, (eg == 8'd0) ? 8'd1 : eg}) - 11'sd126;
        a_op_next.sig       = {8'd0, sig_a} * {24'd0, sig_g};
        a_op_next.force_en  = 1'b1;
        a_op_next.force_val = 32'd0;
        priority if (sfw_pkg::is_nan(alpha_reg))
        begin
            a_op_next.force_val = alpha_reg | sfw_pkg::QUIET_BIT;
        end
        else if (sfw_pkg::is_nan(g_w))
        begin
            a_op_next.force_val = g_w | sfw_pkg::QUIET_BIT;
        end
        else if ((sfw_pkg::is_inf(alpha_reg) && g_zero)
                 || (sfw_pkg::is_inf(g_w) && a_zero))
        begin
            // infinity times zero
            a_op_next.force_val = sfw_pkg::DEFAULT_NAN;
        end
        else if (sfw_pkg::is_inf(alpha_reg) || sfw_pkg::is_inf(g_w))
        begin
            a_op_next.force_val = {p_sign, sfw_pkg::EXP_MAX, 23'd0};
        end
        else if (a_zero || g_zero)
        begin
            a_op_next.force_val = {p_sign, 31'd0};
        end
        else
        begin
            a_op_next.force_en = 1'b0;
        end
    end

    logic            a_valid_reg;
    sfw_pkg::nr_in_t a_op_reg;
    logic [31:0]     a_w_reg;
    logic            a_ready;
    logic            mul_in_ready;

    assign a_ready  = !a_valid_reg || mul_in_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_op_reg <= a_op_next;
            a_w_reg  <= w_in;
        end
    end

    // product normalize and round; the weight rides along
    logic        mul_out_valid;
    logic        b_ready;
    logic [31:0] p_res;
    logic [31:0] p_w;

    sfw_norm_round u_mul_nr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .in_ready  (mul_in_ready),
        .in_op     (a_op_reg),
        .in_aux    (a_w_reg),
        .out_valid (mul_out_valid),
        .out_ready (b_ready),
        .out_res   (p_res),
        .out_aux   (p_w)
    );

    // ------------------------------------------------------------------
    // Stage B: add specials, order by magnitude, align the smaller operand
    // with guard/round/sticky bits.
    // ------------------------------------------------------------------
    logic        swap;
    logic [31:0] x_op;
    logic [31:0] y_op;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [7:0]  d;
    logic [26:0] y_full;
    logic [26:0] y_mask;
    logic [26:0] x27_next;
    logic [26:0] y27_next;
    logic        bf_en_next;
    logic [31:0] bf_val_next;

    always_comb
    begin
        swap   = p_res[30:0] > p_w[30:0];
        x_op   = swap ? p_res : p_w;
        y_op   = swap ? p_w : p_res;
        ex     = (x_op[30:23] == 8'd0) ? 8'd1 : x_op[30:23];
        ey     = (y_op[30:23] == 8'd0) ? 8'd1 : y_op[30:23];
        d      = ex - ey;
        y_full = {y_op[30:23] != 8'd0, y_op[22:0], 3'd0};
        y_mask = (27'd1 << d[4:0]) - 27'd1;
        x27_next = {x_op[30:23] != 8'd0, x_op[22:0], 3'd0};
        if (d >= 8'd27)
        begin
            y27_next = {26'd0, y_full != 27'd0};
        end
        else
        begin
            y27_next = (y_full >> d[4:0]) | {26'd0, (y_full & y_mask) != 27'd0};
        end

        bf_en_next  = 1'b1;
        bf_val_next = 32'd0;
        priority if (sfw_pkg::is_nan(p_w))
        begin
            bf_val_next = p_w | sfw_pkg::QUIET_BIT;
        end
        else if (sfw_pkg::is_nan(p_res))
        begin
            bf_val_next = p_res | sfw_pkg::QUIET_BIT;
        end
        else if (sfw_pkg::is_inf(p_w) && sfw_pkg::is_inf(p_res))
        begin
            // opposite infinities are invalid
            bf_val_next = (p_w[31] == p_res[31]) ? p_w : sfw_pkg::DEFAULT_NAN;
        end
        else if (sfw_pkg::is_inf(p_w))
        begin
            bf_val_next = p_w;
        end
        else if (sfw_pkg::is_inf(p_res))
        begin
            bf_val_next = p_res;
        end
        else
        begin
            bf_en_next = 1'b0;
        end
    end

    logic               b_valid_reg;
    logic [26:0]        b_x27_reg;
    logic [26:0]        b_y27_reg;
    logic               b_sub_reg;
    logic               b_sign_reg;
    logic signed [10:0] b_k_reg;
    logic               b_force_reg;
    logic [31:0]        b_fval_reg;
    logic [31:0]        b_w_reg;
    logic               c_ready;

    assign b_ready = !b_valid_reg || c_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= mul_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && mul_out_valid)
        begin
            b_x27_reg   <= x27_next;
            b_y27_reg   <= y27_next;
            b_sub_reg   <= p_w[31] ^ p_res[31];
            b_sign_reg  <= x_op[31];
            b_k_reg     <= $signed({3'd0, ex}) + 11'sd1;
            b_force_reg <= bf_en_next;
            b_fval_reg  <= bf_val_next;
            b_w_reg     <= p_w;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: add or subtract significands. Exact cancellation gives +0;
    // a sum of same-sign zeros keeps that sign.
    // ------------------------------------------------------------------
    logic [27:0]     sum;
    sfw_pkg::nr_in_t c_op_next;

    always_comb
    begin
        if (b_sub_reg)
        begin
            sum = {1'b0, b_x27_reg} - {1'b0, b_y27_reg};
        end
        else
        begin
            sum = {1'b0, b_x27_reg} + {1'b0, b_y27_reg};
        end
        c_op_next.sign      = b_sign_reg;
        c_op_next.k         = b_k_reg;
        c_op_next.sig       = {sum, 4'd0};
        c_op_next.force_en  = b_force_reg || (sum == 28'd0);
        c_op_next.force_val = b_force_reg ? b_fval_reg
                                          : {b_sign_reg && !b_sub_reg, 31'd0};
    end

    logic            c_valid_reg;
    sfw_pkg::nr_in_t c_op_reg;
    logic [31:0]     c_w_reg;
    logic            add_in_ready;

    assign c_ready = !c_valid_reg || add_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            c_op_reg <= c_op_next;
            c_w_reg  <= b_w_reg;
        end
    end

    // sum normalize and round; its last register is the output register
    logic [31:0] r_res;
    logic [31:0] r_w;

    sfw_norm_round u_add_nr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid_reg),
        .in_ready  (add_in_ready),
        .in_op     (c_op_reg),
        .in_aux    (c_w_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (r_res),
        .out_aux   (r_w)
    );

    assign new_high = r_res[31:16];
    assign new_low  = r_res[15:0];

`ifndef NO_ASSERTIONS
    // a NaN weight always wins and comes back quieted
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sfw_pkg::is_nan(r_w) |-> r_res == (r_w | sfw_pkg::QUIET_BIT))
        else $error("NaN weight not propagated");

    // no signaling NaN ever leaves the block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sfw_pkg::is_nan(r_res) |-> r_res[22])
        else $error("signaling NaN on output");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(r_res))
        else $error("stalled result changed");

    // stage A holds its item while the product pipe is full
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !mul_in_ready |=> a_valid_reg && $stable(a_w_reg))
        else $error("stage A lost an item");
`endif

endmodule
